// File: src/swsp_pkg.sv
// Shared types and constants for the source word splitter.
// Depends on nothing; every other file of the block imports it.
package swsp_pkg;

    localparam int OFFSET_BITS = 20;
    localparam int COLUMN_BITS = 16;

    localparam int WORD_BITS  = 3 * OFFSET_BITS + COLUMN_BITS;
    localparam int TDATA_BITS = ((WORD_BITS + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    typedef logic [OFFSET_BITS-1:0] wide_t;
    typedef logic [COLUMN_BITS-1:0] col_t;

    localparam wide_t WIDE_MAX = '1;
    localparam col_t  COL_MAX  = '1;

    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_DQUOTE = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE = 8'h27;

    // Location and size of one word.
    typedef struct packed {
        wide_t offset;
        wide_t length;
        wide_t line;
        col_t  column;
    } word_t;

    // Everything one input byte causes, in output order: a, b, end marker.
    typedef struct packed {
        logic  eof;
        logic  b_valid;
        word_t b;
        logic  a_valid;
        word_t a;
    } job_t;

    // Queue handshake seen from the writer and from the reader.
    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// File: src/swsp_front.sv
// Front end: accepts source bytes, classifies them and tracks word state.
// Depends on swsp_pkg; pushes one job per byte that causes any result.
module swsp_front import swsp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       queue_full,
    output logic       push,
    output job_t       push_job
);

    logic  prev_naming_reg, prev_naming_next;
    logic  in_literal_reg, in_literal_next;
    word_t pend_reg, pend_next;
    wide_t cur_line_reg, cur_line_next;
    col_t  cur_col_reg, cur_col_next;
    wide_t byte_pos_reg, byte_pos_next;

    logic  accept, naming, blank, boundary, is_lf, lit0, emit_a, grow;
    word_t pend_mid, pend_grown;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        is_lf  = (s_tdata == CHAR_LF);
        naming = (s_tdata >= "a" && s_tdata <= "z") || (s_tdata >= "A" && s_tdata <= "Z") ||
                 (s_tdata >= "0" && s_tdata <= "9") || (s_tdata == "_");
        blank  = (s_tdata == CHAR_SPACE) || (s_tdata == CHAR_TAB) ||
                 (s_tdata == CHAR_CR) || is_lf;
        boundary = !naming || !prev_naming_reg;
        lit0     = in_literal_reg && !is_lf;
        emit_a   = boundary && (pend_reg.length != '0) && !lit0;

        pend_mid = pend_reg;
        if (emit_a) begin
            pend_mid.length = '0;
        end
        grow       = !blank || lit0;
        pend_grown = pend_mid;
        if (grow) begin
            if (pend_mid.length == '0) begin
                pend_grown.offset = byte_pos_reg;
                pend_grown.line   = cur_line_reg;
                pend_grown.column = cur_col_reg;
            end
            pend_grown.length = (pend_mid.length == WIDE_MAX) ? WIDE_MAX
                                                              : pend_mid.length + 1'b1;
        end

        push_job.a_valid = emit_a;
        push_job.a       = pend_reg;
        push_job.b_valid = s_tlast && (pend_grown.length != '0);
        push_job.b       = pend_grown;
        push_job.eof     = s_tlast;
        push             = accept && (emit_a || s_tlast);

        in_literal_next  = lit0 ^ ((s_tdata == CHAR_SQUOTE) || (s_tdata == CHAR_DQUOTE));
        prev_naming_next = naming;
        pend_next        = pend_grown;
        byte_pos_next    = (byte_pos_reg == WIDE_MAX) ? WIDE_MAX : byte_pos_reg + 1'b1;
        cur_line_next    = cur_line_reg;
        if (is_lf) begin
            cur_line_next = (cur_line_reg == WIDE_MAX) ? WIDE_MAX : cur_line_reg + 1'b1;
            cur_col_next  = col_t'(1);
        end else if (s_tdata == CHAR_CR) begin
            cur_col_next = col_t'(1);
        end else begin
            cur_col_next = (cur_col_reg == COL_MAX) ? COL_MAX : cur_col_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_tlast)) begin
            prev_naming_reg <= 1'b0;
            in_literal_reg  <= 1'b0;
            pend_reg.offset <= '0;
            pend_reg.length <= '0;
            pend_reg.line   <= wide_t'(1);
            pend_reg.column <= col_t'(1);
            cur_line_reg    <= wide_t'(1);
            cur_col_reg     <= col_t'(1);
            byte_pos_reg    <= '0;
        end else if (accept) begin
            prev_naming_reg <= prev_naming_next;
            in_literal_reg  <= in_literal_next;
            pend_reg        <= pend_next;
            cur_line_reg    <= cur_line_next;
            cur_col_reg     <= cur_col_next;
            byte_pos_reg    <= byte_pos_next;
        end
    end

endmodule

// File: src/swsp_queue.sv
// Short job queue between the front end and the back end.
// Depends on swsp_pkg for the job type and the depth.
module swsp_queue import swsp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  queue_ctrl_t ctrl,
    input  job_t        push_job,
    output job_t        head_job,
    output queue_stat_t stat
);

    job_t                entries [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;

    assign stat.full  = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_job   = entries[rd_ptr_reg];

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (ctrl.push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (ctrl.pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (ctrl.push && !ctrl.pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (ctrl.pop && !ctrl.push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.push |-> (!stat.full || ctrl.pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pop |-> !stat.empty)
        else $error("pop from empty queue");
    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.push && !ctrl.pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");
`endif

endmodule

// File: src/swsp_back.sv
// Back end: walks the head job's results in order into the output register.
// Depends on swsp_pkg; pops a job once its final result is loaded.
module swsp_back import swsp_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  job_t  head_job,
    input  logic  queue_empty,
    output logic  pop,
    output logic  m_tvalid,
    input  logic  m_tready,
    output logic  out_kind,
    output word_t out_word,
    output logic  out_last
);

    logic  valid_reg;
    logic  kind_reg;
    logic  last_reg;
    word_t word_reg;
    logic [2:0] done_reg;

    logic [2:0] present, remain, chosen;
    logic       load, take, final_item;
    word_t      sel_word;

    assign m_tvalid = valid_reg;
    assign out_kind = kind_reg;
    assign out_word = word_reg;
    assign out_last = last_reg;

    always_comb begin
        present    = {head_job.eof, head_job.b_valid, head_job.a_valid};
        remain     = present & ~done_reg;
        chosen     = remain & (~remain + 3'd1);
        final_item = ((remain & ~chosen) == 3'b000);
        load       = !valid_reg || m_tready;
        take       = load && !queue_empty;
        pop        = take && final_item;
        if (chosen[0]) begin
            sel_word = head_job.a;
        end else if (chosen[1]) begin
            sel_word = head_job.b;
        end else begin
            sel_word = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            done_reg  <= 3'b000;
        end else if (take) begin
            valid_reg <= 1'b1;
            done_reg  <= final_item ? 3'b000 : (done_reg | chosen);
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            word_reg <= sel_word;
            kind_reg <= chosen[2];
            last_reg <= final_item;
        end
    end

endmodule

// File: src/source_word_splitter_core.sv
// Top level of the source word splitter: front end, job queue, back end.
// Depends on swsp_pkg, swsp_front, swsp_queue and swsp_back.
//
//   channel  | dir | tdata                                  | tuser     | tlast
//   ---------+-----+----------------------------------------+-----------+-----------
//   s_ bytes | in  | char_byte[7:0]                         | -         | last_byte
//   m_ words | out | offset, length, line, column (low up)  | item_kind | run_last
//
// A byte is taken every cycle while the two-entry job queue has room; a byte
// that closes no word only updates the front-end state. Results leave at one
// word per cycle from the back end's output register while m_tready is high,
// and a byte that causes several results (up to three) sends them in order.
// Reset is synchronous on aresetn low and needs no clearing pass.
// A stall on m_tready fills the queue and then drops s_tready; the two sides
// otherwise run independently.
module source_word_splitter_core import swsp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input bytes.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // char_byte[7:0]
    input  logic                  s_tlast,   // last_byte
    // Result words.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_BITS-1:0] m_tdata,   // word_offset, word_length, word_line,
                                             // word_column, then zero fill
    output logic                  m_tuser,   // item_kind
    output logic                  m_tlast    // run_last
);

    job_t        push_job, head_job;
    queue_ctrl_t q_ctrl;
    queue_stat_t q_stat;
    word_t       out_word;

    // The front end classifies each byte and pushes a job only when the
    // byte closes a word or ends the buffer.
    swsp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (q_stat.full),
        .push       (q_ctrl.push),
        .push_job   (push_job)
    );

    swsp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (q_ctrl),
        .push_job (push_job),
        .head_job (head_job),
        .stat     (q_stat)
    );

    // The back end emits the head job's results one per cycle while m_tready allows
    // and marks the final one of each job with tlast.
    swsp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_job    (head_job),
        .queue_empty (q_stat.empty),
        .pop         (q_ctrl.pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_kind    (m_tuser),
        .out_word    (out_word),
        .out_last    (m_tlast)
    );

    // Offset sits in the lowest bits, column highest, then zero fill.
    assign m_tdata = TDATA_BITS'({out_word.column, out_word.line,
                                  out_word.length, out_word.offset});

endmodule

// File: sim/tb_source_word_splitter_core.sv
// Self-checking testbench for source_word_splitter_core.
// Depends on swsp_pkg and the block's RTL; a small class predicts and checks.
`timescale 1ns / 100ps

module tb_source_word_splitter_core;
    import swsp_pkg::*;

    // Cycles without any handshake before the run is declared hung.
    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_ITEMS = 150;

    // One predicted result word, in the order the fields are checked.
    typedef struct packed {
        logic  kind;
        wide_t offset;
        wide_t length;
        wide_t line;
        col_t  column;
        logic  last;
    } word_item_t;

    // Tracks the splitter's state byte by byte and holds the words it owes.
    class word_ledger;
        bit         prev_naming;
        bit         in_literal;
        wide_t      pend_len;
        wide_t      pend_off;
        wide_t      pend_line;
        col_t       pend_col;
        wide_t      cur_line;
        col_t       cur_col;
        wide_t      byte_pos;
        word_item_t words_due[$];
        int         errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            prev_naming = 1'b0;
            in_literal  = 1'b0;
            pend_len    = '0;
            pend_off    = '0;
            pend_line   = wide_t'(1);
            pend_col    = col_t'(1);
            cur_line    = wide_t'(1);
            cur_col     = col_t'(1);
            byte_pos    = '0;
        endfunction

        function wide_t bump_wide(wide_t v);
            return (v == WIDE_MAX) ? v : v + 1'b1;
        endfunction

        function col_t bump_col(col_t v);
            return (v == COL_MAX) ? v : v + 1'b1;
        endfunction

        function word_item_t flush_pending();
            word_item_t w;
            w = '{kind: 1'b0, offset: pend_off, length: pend_len, line: pend_line,
                  column: pend_col, last: 1'b0};
            pend_len = '0;
            return w;
        endfunction

        // Advances the state by one accepted byte and queues the words it causes.
        function void take_byte(logic [7:0] c, bit last);
            word_item_t step_words[$];
            bit         naming;
            bit         blank;
            naming = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                     (c >= "0" && c <= "9") || c == "_";
            blank  = c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF;

            // A newline always ends a literal before anything else happens.
            if (c == CHAR_LF)
                in_literal = 1'b0;
            if ((!naming || !prev_naming) && pend_len != 0 && !in_literal)
                step_words.push_back(flush_pending());
            if (!blank || in_literal) begin
                if (pend_len == 0) begin
                    pend_off  = byte_pos;
                    pend_line = cur_line;
                    pend_col  = cur_col;
                end
                pend_len = bump_wide(pend_len);
            end
            if (c == CHAR_DQUOTE || c == CHAR_SQUOTE)
                in_literal = ~in_literal;

            if (c == CHAR_LF) begin
                cur_line = bump_wide(cur_line);
                cur_col  = col_t'(1);
            end else if (c == CHAR_CR) begin
                cur_col = col_t'(1);
            end else begin
                cur_col = bump_col(cur_col);
            end
            byte_pos    = bump_wide(byte_pos);
            prev_naming = naming;

            // The final byte flushes what is pending, then the end marker follows.
            if (last) begin
                if (pend_len != 0)
                    step_words.push_back(flush_pending());
                step_words.push_back('{kind: 1'b1, offset: '0, length: '0, line: '0,
                                       column: '0, last: 1'b0});
                clear();
            end
            if (step_words.size() > 0)
                step_words[$].last = 1'b1;
            foreach (step_words[i])
                words_due.push_back(step_words[i]);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        // Compares one accepted result word with the oldest one owed.
        function void match_word(logic [TDATA_BITS-1:0] data, logic user, logic lst);
            word_item_t w;
            if (words_due.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual tdata %0h",
                         $time, data);
                errors++;
                return;
            end
            w = words_due.pop_front();
            compare("item_kind", w.kind, user);
            compare("word_offset", w.offset, data[OFFSET_BITS-1:0]);
            compare("word_length", w.length, data[2*OFFSET_BITS-1:OFFSET_BITS]);
            compare("word_line", w.line, data[3*OFFSET_BITS-1:2*OFFSET_BITS]);
            compare("word_column", w.column, data[3*OFFSET_BITS+COLUMN_BITS-1:3*OFFSET_BITS]);
            compare("run_last", w.last, lst);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_BITS-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    word_ledger ledger;
    // While calm is set neither side inserts idle cycles.
    bit         calm        = 1'b0;
    // While set, any byte may randomly close its buffer.
    bit         random_ends = 1'b0;
    int         bytes_sent  = 0;

    string NAME_CHARS = "qwertyuiopasdfghjklzxcvbnmQWERTYUIOPASDFGHJKLZXCVBNM0123456789_";
    string OPS        = "+-*/=;(){}[].,<>!&|#@";

    source_word_splitter_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Offers one source byte after a random gap and waits until it is taken.
    // Valid is only lowered when a gap is drawn, so back-to-back bytes keep it high.
    task automatic send_byte(input logic [7:0] b, input bit last);
        int gap;
        bit end_flag;
        gap      = calm ? 0 : $urandom_range(0, 7);
        end_flag = last || (random_ends && $urandom_range(0, 24) == 0);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= end_flag;
        do @(posedge aclk); while (!s_tready);
        ledger.take_byte(b, end_flag);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input bit last_at_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last_at_end && i == s.len() - 1);
    endtask

    // Holds the input side quiet until every owed word has come out.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (ledger.words_due.size() != 0)
            @(posedge aclk);
    endtask

    // Result side: random stall before each word, then accept and check it.
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 7);
            repeat (stall) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            ledger.match_word(m_tdata, m_tuser, m_tlast);
        end
    end

    // Ends a hung run: counts consecutive cycles in which no word moves.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("tb_source_word_splitter_core: FAIL");
        $finish;
    end

    initial begin : stimulus
        int         pick;
        int         len;
        int         rand_start;
        logic [7:0] quote;
        ledger = new();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed buffer: an identifier with digit and underscore, blanks of every
        // kind, an operator, both quote styles, a blank inside a literal, CR and LF,
        // an unclosed literal ended by a newline, and non-ASCII and control bytes.
        send_text("x_9 Z+\"a b\"\t'q'\r\n\"u\n", 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // The final byte here flushes the pending word, itself and the end marker.
        send_byte(";", 1'b1);

        // Let the output run dry once before going on.
        wait_drained();

        // A one-byte buffer shows the state starting over at offset 0, line 1.
        send_byte("a", 1'b1);
        // A buffer holding only a blank yields the end marker alone.
        send_byte(CHAR_SPACE, 1'b1);
        // An unclosed literal is flushed by the final byte.
        send_text("\"k", 1'b1);

        // Random part: mostly well-formed tokens with random content, some noise.
        // Every other stretch of about 30 bytes runs without idle cycles.
        random_ends = 1'b1;
        rand_start  = bytes_sent;
        while (bytes_sent < rand_start + RANDOM_ITEMS) begin
            calm = (((bytes_sent - rand_start) / 30) % 2) == 1;
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                len = $urandom_range(1, 6);
                repeat (len)
                    send_byte(NAME_CHARS[$urandom_range(0, NAME_CHARS.len() - 1)], 1'b0);
            end else if (pick < 50) begin
                send_byte(OPS[$urandom_range(0, OPS.len() - 1)], 1'b0);
            end else if (pick < 65) begin
                case ($urandom_range(0, 3))
                    0: send_byte(CHAR_SPACE, 1'b0);
                    1: send_byte(CHAR_TAB, 1'b0);
                    2: send_byte(CHAR_CR, 1'b0);
                    default: send_byte(CHAR_LF, 1'b0);
                endcase
            end else if (pick < 80) begin
                // A literal that is closed, left open, or cut by a newline.
                quote = $urandom_range(0, 1) ? CHAR_DQUOTE : CHAR_SQUOTE;
                send_byte(quote, 1'b0);
                len = $urandom_range(0, 5);
                repeat (len)
                    send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
                case ($urandom_range(0, 3))
                    0: send_byte(CHAR_LF, 1'b0);
                    1: ;
                    default: send_byte(quote, 1'b0);
                endcase
            end else begin
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end
        random_ends = 1'b0;
        calm        = 1'b0;
        send_byte(CHAR_SPACE, 1'b1);

        // Wait for every owed word, then a short tail to catch stray output.
        wait_drained();
        repeat (16) @(posedge aclk);
        if (ledger.errors == 0)
            $display("tb_source_word_splitter_core: PASS");
        else
            $display("tb_source_word_splitter_core: FAIL");
        $finish;
    end

endmodule

// File: sim.f
src/swsp_pkg.sv
src/swsp_front.sv
src/swsp_queue.sv
src/swsp_back.sv
src/source_word_splitter_core.sv
sim/tb_source_word_splitter_core.sv
